// File: hw/rtl/vcm_pkg.sv
// Shared types and constants of the vorticity colormap pixel unit.
// Used by the channel interfaces, the controller, the datapath and the checker.
// Depends on nothing.
package vcm_pkg;

    localparam int ROW_W = 7;
    localparam int COL_W = 9;
    localparam int VEL_W = 16;
    localparam int COLOR_W = 8;
    localparam int MIN_W = 18;
    localparam int SCALE_W = 24;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W = 24;

    localparam int GRID_COLUMNS_DEFAULT = 512;
    localparam int GRID_ROWS_DEFAULT = 128;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_VORT_MINIMUM = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_VORT_SCALE = 1'd1;

    localparam logic signed [MIN_W-1:0] VORT_MINIMUM_RESET = -18'sd655;
    localparam logic [SCALE_W-1:0] VORT_SCALE_RESET = 24'd3276800;

    // Which grid cells the two memories look at in one access.
    typedef enum logic [1:0] {
        ACC_WRITE,
        ACC_FIRST,
        ACC_SECOND,
        ACC_THIRD
    } access_t;

    typedef struct packed {
        logic    load_item;
        logic    reduce;
        logic    ram_we;
        logic    ram_re;
        access_t access;
        logic    cap_center;
        logic    cap_plus;
        logic    calc_vort;
        logic    calc_offset;
        logic    calc_scale;
        logic    calc_sat;
        logic    load_pixel;
    } vcm_cmd_t;

    typedef struct packed {
        logic is_read;
    } vcm_status_t;

endpackage

// File: hw/rtl/vcm_channels.sv
// Handshake channel interfaces: cell requests, pixel words and register writes.
// Depends on vcm_pkg.
interface vcm_request_if;
    import vcm_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    operation;
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        column;
    logic signed [VEL_W-1:0] x_velocity;
    logic signed [VEL_W-1:0] y_velocity;
    logic                    solid;

    modport source (output valid, operation, row, column, x_velocity, y_velocity, solid,
                    input ready);
    modport sink (input valid, operation, row, column, x_velocity, y_velocity, solid,
                  output ready);
endinterface

interface vcm_pixel_if;
    import vcm_pkg::*;

    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink (input valid, red, green, blue, output ready);
endinterface

interface vcm_cfg_if;
    import vcm_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/vcm_ram.sv
// Generic single-port RAM with registered read data.
// Depends on nothing.
module vcm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

// File: hw/rtl/vcm_ctrl.sv
// Sequencer of the pixel unit: walks each word through reduce, memory access and math.
// Depends on vcm_pkg; drives vcm_datapath through vcm_cmd_t.
module vcm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  vcm_pkg::vcm_status_t status,
    output vcm_pkg::vcm_cmd_t    cmd
);
    import vcm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_REDUCE,
        S_WRITE,
        S_READ0,
        S_READ1,
        S_READ2,
        S_VORT,
        S_OFFSET,
        S_SCALE,
        S_SAT,
        S_BLEND
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   pixel_free;

    assign req_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign pixel_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd = '0;
        cmd.access = ACC_WRITE;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load_item = req_valid;
                if (req_valid)
                begin
                    state_next = S_REDUCE;
                end
            end
            S_REDUCE:
            begin
                cmd.reduce = 1'b1;
                state_next = status.is_read ? S_READ0 : S_WRITE;
            end
            S_WRITE:
            begin
                cmd.ram_we = 1'b1;
                state_next = S_IDLE;
            end
            S_READ0:
            begin
                cmd.ram_re = 1'b1;
                cmd.access = ACC_FIRST;
                state_next = S_READ1;
            end
            S_READ1:
            begin
                cmd.ram_re = 1'b1;
                cmd.access = ACC_SECOND;
                cmd.cap_center = 1'b1;
                state_next = S_READ2;
            end
            S_READ2:
            begin
                cmd.ram_re = 1'b1;
                cmd.access = ACC_THIRD;
                cmd.cap_plus = 1'b1;
                state_next = S_VORT;
            end
            S_VORT:
            begin
                cmd.calc_vort = 1'b1;
                state_next = S_OFFSET;
            end
            S_OFFSET:
            begin
                cmd.calc_offset = 1'b1;
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.calc_scale = 1'b1;
                state_next = S_SAT;
            end
            S_SAT:
            begin
                cmd.calc_sat = 1'b1;
                state_next = S_BLEND;
            end
            S_BLEND:
            begin
                // The finished pixel waits here until the output register is free.
                if (pixel_free)
                begin
                    cmd.load_pixel = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: hw/rtl/vcm_datapath.sv
// Datapath of the pixel unit: coordinate reduction, memory addressing, curl,
// scaling and color blend, plus the two configuration registers.
// Depends on vcm_pkg; controlled by vcm_ctrl.
module vcm_datapath #(
    parameter int GRID_COLUMNS = vcm_pkg::GRID_COLUMNS_DEFAULT,
    parameter int GRID_ROWS = vcm_pkg::GRID_ROWS_DEFAULT
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  vcm_pkg::vcm_cmd_t                           cmd,
    output vcm_pkg::vcm_status_t                        status,
    input  logic                                        cfg_we,
    input  logic [vcm_pkg::CFG_INDEX_W-1:0]             cfg_index,
    input  logic [vcm_pkg::CFG_DATA_W-1:0]              cfg_data,
    input  logic                                        operation,
    input  logic [vcm_pkg::ROW_W-1:0]                   row,
    input  logic [vcm_pkg::COL_W-1:0]                   column,
    input  logic signed [vcm_pkg::VEL_W-1:0]            x_velocity,
    input  logic signed [vcm_pkg::VEL_W-1:0]            y_velocity,
    input  logic                                        solid,
    output logic                                        ram_we,
    output logic                                        ram_re,
    output logic [$clog2(GRID_ROWS*GRID_COLUMNS)-1:0]   y_addr,
    output logic [$clog2(GRID_ROWS*GRID_COLUMNS)-1:0]   x_addr,
    output logic [vcm_pkg::VEL_W:0]                     y_wdata,
    output logic [vcm_pkg::VEL_W-1:0]                   x_wdata,
    input  logic [vcm_pkg::VEL_W:0]                     y_rdata,
    input  logic [vcm_pkg::VEL_W-1:0]                   x_rdata,
    output logic [vcm_pkg::COLOR_W-1:0]                 red,
    output logic [vcm_pkg::COLOR_W-1:0]                 green,
    output logic [vcm_pkg::COLOR_W-1:0]                 blue
);
    import vcm_pkg::*;

    localparam int CELLS = GRID_ROWS * GRID_COLUMNS;
    localparam int AW = $clog2(CELLS);
    localparam int RW = $clog2(GRID_ROWS);
    localparam int CW = $clog2(GRID_COLUMNS);
    localparam int VORT_W = VEL_W + 2;
    localparam int OFF_W = MIN_W + 1;
    localparam int PROD_W = (OFF_W - 1) + SCALE_W;
    localparam int T_W = 17;
    localparam int ACC_W = T_W + COLOR_W;
    localparam logic [T_W-1:0] T_ONE = 17'd65536;
    localparam logic [T_W-1:0] T_HALF = 17'd32768;

    localparam logic [COLOR_W-1:0] LOW_RED = 8'd49;
    localparam logic [COLOR_W-1:0] LOW_GREEN = 8'd54;
    localparam logic [COLOR_W-1:0] LOW_BLUE = 8'd149;
    localparam logic [COLOR_W-1:0] MID_LEVEL = 8'd255;
    localparam logic [COLOR_W-1:0] HIGH_RED = 8'd165;
    localparam logic [COLOR_W-1:0] HIGH_GREEN = 8'd0;
    localparam logic [COLOR_W-1:0] HIGH_BLUE = 8'd38;

    // Rounded linear mix of two channel levels, weight u out of 65536.
    function automatic logic [COLOR_W-1:0] mix(input logic [T_W-1:0] u,
                                               input logic [COLOR_W-1:0] c1,
                                               input logic [COLOR_W-1:0] c2);
        logic [ACC_W-1:0] acc;
        acc = ACC_W'(T_ONE - u) * ACC_W'(c1) + ACC_W'(u) * ACC_W'(c2) + ACC_W'(T_HALF);
        return acc[16 +: COLOR_W];
    endfunction

    logic signed [MIN_W-1:0]   minimum_reg;
    logic [SCALE_W-1:0]        scale_reg;

    logic                      op_reg;
    logic [ROW_W-1:0]          row_in_reg;
    logic [COL_W-1:0]          col_in_reg;
    logic [VEL_W-1:0]          xv_reg;
    logic [VEL_W-1:0]          yv_reg;
    logic                      solid_in_reg;
    logic [RW-1:0]             r_reg;
    logic [CW-1:0]             c_reg;
    logic                      solid_reg;
    logic signed [VEL_W-1:0]   xp_reg;
    logic signed [VEL_W-1:0]   xm_reg;
    logic signed [VEL_W-1:0]   ycp_reg;
    logic signed [VORT_W-1:0]  vort_reg;
    logic signed [OFF_W-1:0]   off_reg;
    logic [PROD_W-1:0]         prod_reg;
    logic [T_W-1:0]            t_reg;
    logic [COLOR_W-1:0]        red_reg;
    logic [COLOR_W-1:0]        green_reg;
    logic [COLOR_W-1:0]        blue_reg;

    logic [ROW_W-1:0]          row_mod;
    logic [COL_W-1:0]          col_mod;
    logic [RW-1:0]             r_plus;
    logic [RW-1:0]             r_minus;
    logic [CW-1:0]             c_plus;
    logic [CW-1:0]             c_minus;
    logic [RW-1:0]             x_row;
    logic [CW-1:0]             y_col;
    logic signed [VEL_W-1:0]   ycm;
    logic signed [VEL_W:0]     dy;
    logic signed [VEL_W:0]     dx;
    logic [PROD_W-17:0]        scaled;
    logic [T_W-1:0]            t_next;
    logic [T_W-1:0]            u;
    logic                      upper_half;

    assign status.is_read = (op_reg == OP_READ);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            minimum_reg <= VORT_MINIMUM_RESET;
            scale_reg <= VORT_SCALE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_VORT_MINIMUM: minimum_reg <= cfg_data[MIN_W-1:0];
                REG_VORT_SCALE:   scale_reg <= cfg_data[SCALE_W-1:0];
            endcase
        end
    end

    // Coordinates wrap onto the grid by restoring reduction against shifted sizes.
    always_comb
    begin
        row_mod = row_in_reg;
        for (int k = ROW_W - 1; k >= 0; k--)
        begin
            if (32'(row_mod) >= (GRID_ROWS << k))
            begin
                row_mod = row_mod - ROW_W'(GRID_ROWS << k);
            end
        end
        col_mod = col_in_reg;
        for (int k = COL_W - 1; k >= 0; k--)
        begin
            if (32'(col_mod) >= (GRID_COLUMNS << k))
            begin
                col_mod = col_mod - COL_W'(GRID_COLUMNS << k);
            end
        end
    end

    assign r_plus = (r_reg == RW'(GRID_ROWS - 1)) ? '0 : r_reg + 1'b1;
    assign r_minus = (r_reg == '0) ? RW'(GRID_ROWS - 1) : r_reg - 1'b1;
    assign c_plus = (c_reg == CW'(GRID_COLUMNS - 1)) ? '0 : c_reg + 1'b1;
    assign c_minus = (c_reg == '0) ? CW'(GRID_COLUMNS - 1) : c_reg - 1'b1;

    // The y memory reads the center, right and left cells; the x memory reads
    // the cells below and above.
    always_comb
    begin
        unique case (cmd.access)
            ACC_WRITE:
            begin
                y_col = c_reg;
                x_row = r_reg;
            end
            ACC_FIRST:
            begin
                y_col = c_reg;
                x_row = r_plus;
            end
            ACC_SECOND:
            begin
                y_col = c_plus;
                x_row = r_minus;
            end
            ACC_THIRD:
            begin
                y_col = c_minus;
                x_row = r_minus;
            end
        endcase
    end

    assign y_addr = AW'(r_reg) * AW'(GRID_COLUMNS) + AW'(y_col);
    assign x_addr = AW'(x_row) * AW'(GRID_COLUMNS) + AW'(c_reg);
    assign ram_we = cmd.ram_we;
    assign ram_re = cmd.ram_re;
    assign y_wdata = {solid_in_reg, yv_reg};
    assign x_wdata = xv_reg;

    assign ycm = y_rdata[VEL_W-1:0];
    assign dy = (VEL_W+1)'(ycp_reg) - (VEL_W+1)'(ycm);
    assign dx = (VEL_W+1)'(xp_reg) - (VEL_W+1)'(xm_reg);

    assign scaled = prod_reg[PROD_W-1:16];
    assign t_next = (scaled > (PROD_W-16)'(T_ONE)) ? T_ONE : T_W'(scaled);

    assign upper_half = (t_reg > T_HALF);
    assign u = upper_half ? T_W'((t_reg - T_HALF) << 1) : T_W'(t_reg << 1);

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg <= operation;
            row_in_reg <= row;
            col_in_reg <= column;
            xv_reg <= x_velocity;
            yv_reg <= y_velocity;
            solid_in_reg <= solid;
        end
        if (cmd.reduce)
        begin
            r_reg <= RW'(row_mod);
            c_reg <= CW'(col_mod);
        end
        if (cmd.cap_center)
        begin
            solid_reg <= y_rdata[VEL_W];
            xp_reg <= x_rdata;
        end
        if (cmd.cap_plus)
        begin
            ycp_reg <= y_rdata[VEL_W-1:0];
            xm_reg <= x_rdata;
        end
        if (cmd.calc_vort)
        begin
            vort_reg <= VORT_W'(dy) - VORT_W'(dx);
        end
        if (cmd.calc_offset)
        begin
            off_reg <= OFF_W'(vort_reg) - OFF_W'(minimum_reg);
        end
        if (cmd.calc_scale)
        begin
            // A non-positive offset maps to t of zero.
            if (off_reg[OFF_W-1] || off_reg == '0)
            begin
                prod_reg <= '0;
            end
            else
            begin
                prod_reg <= PROD_W'(off_reg[OFF_W-2:0]) * PROD_W'(scale_reg);
            end
        end
        if (cmd.calc_sat)
        begin
            t_reg <= t_next;
        end
        if (cmd.load_pixel)
        begin
            if (solid_reg)
            begin
                red_reg <= '0;
                green_reg <= '0;
                blue_reg <= '0;
            end
            else if (upper_half)
            begin
                red_reg <= mix(u, MID_LEVEL, HIGH_RED);
                green_reg <= mix(u, MID_LEVEL, HIGH_GREEN);
                blue_reg <= mix(u, MID_LEVEL, HIGH_BLUE);
            end
            else
            begin
                red_reg <= mix(u, LOW_RED, MID_LEVEL);
                green_reg <= mix(u, LOW_GREEN, MID_LEVEL);
                blue_reg <= mix(u, LOW_BLUE, MID_LEVEL);
            end
        end
    end

    assign red = red_reg;
    assign green = green_reg;
    assign blue = blue_reg;

endmodule

// File: hw/rtl/vorticity_colormap_pixel.sv
// Vorticity colormap pixel unit: stores grid cells and returns the color of a cell.
// Depends on vcm_pkg, vcm_channels, vcm_ram, vcm_ctrl and vcm_datapath.
// A write word passes through the reduce and write states before the next word is taken.
// A read word passes through reduce, three reads of two single-port cell memories and
// five math steps before its pixel shows; no new word is taken until the pixel is loaded.
// Reset clears the sequencer and loads the register defaults; cell memories stay as they are.
module vorticity_colormap_pixel #(
    parameter int GRID_COLUMNS = vcm_pkg::GRID_COLUMNS_DEFAULT,
    parameter int GRID_ROWS = vcm_pkg::GRID_ROWS_DEFAULT
) (
    input logic          clk,
    input logic          rst_n,
    vcm_request_if.sink  request,
    vcm_pixel_if.source  pixel,
    vcm_cfg_if.sink      cfg
);
    import vcm_pkg::*;

    localparam int CELLS = GRID_ROWS * GRID_COLUMNS;
    localparam int AW = $clog2(CELLS);

    vcm_cmd_t         cmd;
    vcm_status_t      status;
    logic             ram_we;
    logic             ram_re;
    logic [AW-1:0]    y_addr;
    logic [AW-1:0]    x_addr;
    logic [VEL_W:0]   y_wdata;
    logic [VEL_W-1:0] x_wdata;
    logic [VEL_W:0]   y_rdata;
    logic [VEL_W-1:0] x_rdata;

    // Register writes are taken at any time.
    assign cfg.ready = 1'b1;

    vcm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .req_ready (request.ready),
        .out_valid (pixel.valid),
        .out_ready (pixel.ready),
        .status    (status),
        .cmd       (cmd)
    );

    vcm_datapath #(
        .GRID_COLUMNS (GRID_COLUMNS),
        .GRID_ROWS    (GRID_ROWS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_we     (cfg.valid),
        .cfg_index  (cfg.index),
        .cfg_data   (cfg.data),
        .operation  (request.operation),
        .row        (request.row),
        .column     (request.column),
        .x_velocity (request.x_velocity),
        .y_velocity (request.y_velocity),
        .solid      (request.solid),
        .ram_we     (ram_we),
        .ram_re     (ram_re),
        .y_addr     (y_addr),
        .x_addr     (x_addr),
        .y_wdata    (y_wdata),
        .x_wdata    (x_wdata),
        .y_rdata    (y_rdata),
        .x_rdata    (x_rdata),
        .red        (pixel.red),
        .green      (pixel.green),
        .blue       (pixel.blue)
    );

    // Vertical velocity with the solid flag on top.
    vcm_ram #(
        .WIDTH (VEL_W + 1),
        .DEPTH (CELLS)
    ) u_y_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (y_addr),
        .wdata (y_wdata),
        .rdata (y_rdata)
    );

    vcm_ram #(
        .WIDTH (VEL_W),
        .DEPTH (CELLS)
    ) u_x_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (x_addr),
        .wdata (x_wdata),
        .rdata (x_rdata)
    );

endmodule

// File: hw/rtl/vcm_checker.sv
// Port-level checker for the pixel unit, attached to the top level by bind.
// Depends on vcm_pkg and vorticity_colormap_pixel.
module vcm_checker (
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic req_operation,
    input logic pix_valid,
    input logic pix_ready,
    input logic [vcm_pkg::COLOR_W-1:0] pix_red,
    input logic [vcm_pkg::COLOR_W-1:0] pix_green,
    input logic [vcm_pkg::COLOR_W-1:0] pix_blue
);
    import vcm_pkg::*;

    logic [1:0] pending_reg;
    logic [1:0] pending_next;
    logic       read_taken;
    logic       pixel_taken;

    assign read_taken = req_valid && req_ready && (req_operation == OP_READ);
    assign pixel_taken = pix_valid && pix_ready;

    // Reads accepted whose pixel word has not yet been taken.
    always_comb
    begin
        pending_next = pending_reg;
        if (read_taken && !pixel_taken)
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (!read_taken && pixel_taken)
        begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_pixel_held: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !pix_ready |=> pix_valid && $stable(pix_red) && $stable(pix_green)
                                    && $stable(pix_blue))
        else $error("pixel word changed while stalled");

    a_pixel_has_read: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid |-> pending_reg != 2'd0)
        else $error("pixel word without an accepted read");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("more than two reads in flight");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken again right after a word was accepted");

endmodule

bind vorticity_colormap_pixel vcm_checker u_vcm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (request.valid),
    .req_ready     (request.ready),
    .req_operation (request.operation),
    .pix_valid     (pixel.valid),
    .pix_ready     (pixel.ready),
    .pix_red       (pixel.red),
    .pix_green     (pixel.green),
    .pix_blue      (pixel.blue)
);
